[src/aps_pkg.sv]
// Shared types, codes and the command-burst beat table of the ATA PIO read sequencer.
// Depends on nothing; every other file of the block except aps_fifo imports it.
`default_nettype none

package aps_pkg;

  // Field widths
  localparam int unsigned LBA_W   = 48;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned WC_W    = 9;

  localparam int unsigned WORDS_PER_SECTOR = 256;

  // Result kinds
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_DATA  = 3'd2;
  localparam logic [2:0] KIND_OK    = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // Command block register offsets
  localparam logic [2:0] OFF_DATA     = 3'd0;
  localparam logic [2:0] OFF_SECCOUNT = 3'd2;
  localparam logic [2:0] OFF_LBA0     = 3'd3;
  localparam logic [2:0] OFF_LBA1     = 3'd4;
  localparam logic [2:0] OFF_LBA2     = 3'd5;
  localparam logic [2:0] OFF_DEVSEL   = 3'd6;
  localparam logic [2:0] OFF_CMD      = 3'd7;

  // Job actions passed from front to back
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_RD_CMD  = 3'd1;
  localparam logic [2:0] ACT_RD_DATA = 3'd2;
  localparam logic [2:0] ACT_OK      = 3'd3;
  localparam logic [2:0] ACT_ERR     = 3'd4;
  localparam logic [2:0] ACT_CHUNK   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_LONG_MODE = 2'd0;
  localparam logic [1:0] CFG_DRIVE     = 2'd1;
  localparam logic [1:0] CFG_IO_BASE   = 2'd2;

  localparam logic [15:0] IO_BASE_RST = 16'h01F0;

  // Device and command bytes
  localparam logic [7:0] DEV_BASE   = 8'hE0;
  localparam logic [7:0] CMD_READ28 = 8'h20;
  localparam logic [7:0] CMD_READ48 = 8'h24;

  localparam int unsigned CHUNK_LIMIT28 = 255;
  localparam int unsigned CHUNK_LIMIT48 = 65535;

  // Status bits
  localparam logic [7:0] ST_FAULT_MASK = 8'h21;
  localparam logic [7:0] ST_BSY        = 8'h80;
  localparam logic [7:0] ST_DRQ        = 8'h08;

  // Beats per command burst, closing status read included
  localparam logic [3:0] BURST_BEATS28 = 4'd7;
  localparam logic [3:0] BURST_BEATS48 = 4'd11;

  typedef struct packed {
    logic              operation;
    logic [LBA_W-1:0]  start_lba;
    logic [CNT_W-1:0]  sector_count;
    logic [WORD_W-1:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [15:0]       bus_address;
    logic [7:0]        write_byte;
    logic [WORD_W-1:0] data_word;
    logic              last;
  } res_t;

  typedef struct packed {
    logic               has_data;
    logic [WORD_W-1:0]  data;
    logic [2:0]         act;
    logic               long_mode;
    logic               drive;
    logic [CHUNK_W-1:0] chunk;
    logic [LBA_W-1:0]   lba;
  } job_t;

  typedef struct packed {
    logic       is_read;
    logic [2:0] off;
    logic [7:0] wbyte;
  } beat_t;

  // One beat of a chunk's command burst
  function automatic beat_t chunk_beat(input logic               long_mode,
                                       input logic               drive,
                                       input logic [CHUNK_W-1:0] chunk,
                                       input logic [LBA_W-1:0]   lba,
                                       input logic [3:0]         idx);
    beat_t      b;
    logic [7:0] dev;
    dev       = DEV_BASE | {3'b000, drive, 4'b0000};
    b.is_read = 1'b0;
    b.off     = OFF_CMD;
    b.wbyte   = 8'h00;
    if (long_mode) begin
      case (idx)
        4'd0: begin b.off = OFF_DEVSEL;   b.wbyte = dev;           end
        4'd1: begin b.off = OFF_SECCOUNT; b.wbyte = chunk[15:8];   end
        4'd2: begin b.off = OFF_SECCOUNT; b.wbyte = chunk[7:0];    end
        4'd3: begin b.off = OFF_LBA0;     b.wbyte = lba[31:24];    end
        4'd4: begin b.off = OFF_LBA0;     b.wbyte = lba[7:0];      end
        4'd5: begin b.off = OFF_LBA1;     b.wbyte = lba[39:32];    end
        4'd6: begin b.off = OFF_LBA1;     b.wbyte = lba[15:8];     end
        4'd7: begin b.off = OFF_LBA2;     b.wbyte = lba[47:40];    end
        4'd8: begin b.off = OFF_LBA2;     b.wbyte = lba[23:16];    end
        4'd9: begin b.off = OFF_CMD;      b.wbyte = CMD_READ48;    end
        default: begin b.is_read = 1'b1; b.off = OFF_CMD;         end
      endcase
    end else begin
      case (idx)
        4'd0: begin b.off = OFF_DEVSEL;   b.wbyte = dev | {4'h0, lba[27:24]}; end
        4'd1: begin b.off = OFF_SECCOUNT; b.wbyte = chunk[7:0];               end
        4'd2: begin b.off = OFF_LBA0;     b.wbyte = lba[7:0];                 end
        4'd3: begin b.off = OFF_LBA1;     b.wbyte = lba[15:8];                end
        4'd4: begin b.off = OFF_LBA2;     b.wbyte = lba[23:16];               end
        4'd5: begin b.off = OFF_CMD;      b.wbyte = CMD_READ28;               end
        default: begin b.is_read = 1'b1; b.off = OFF_CMD;                    end
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[src/aps_fifo.sv]
// Small register queue used for the job queue and the result queue.
// Depends on nothing; data travels as a plain vector.
`default_nettype none

module aps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[src/aps_front.sv]
// Front end: accepts start and response items, tracks the transfer and emits at most one job each.
// Depends on aps_pkg for the item and job types and the action codes.
`default_nettype none

module aps_front #(
  parameter int unsigned MAX_SECTORS = 8192
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire aps_pkg::in_item_t item_i,
  input  wire logic              long_mode_i,
  input  wire logic              drive_i,
  output aps_pkg::job_t          job_o,
  output logic                   job_push_o
);
  import aps_pkg::*;

  localparam int unsigned RW = $clog2(MAX_SECTORS + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DUMMY = 2'd1;
  localparam logic [1:0] PH_POLL  = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  localparam logic [1:0]      DUMMY_READS = 2'd3;
  localparam logic [WC_W-1:0] WORDS_END   = WC_W'(WORDS_PER_SECTOR);

  logic [1:0]         phase_q, phase_d;
  logic [LBA_W-1:0]   blk_q, blk_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [CHUNK_W-1:0] cl_q, cl_d;
  logic [WC_W-1:0]    word_q, word_d;
  logic [1:0]         dummy_q, dummy_d;

  logic [31:0]        cnt32, sat32, rem32, lim32, chunk32;
  logic [RW-1:0]      sat_cnt, rem_dec, chunk_rem;
  logic [CHUNK_W-1:0] cl_dec;
  logic [WC_W-1:0]    word_inc;
  logic [1:0]         dummy_inc;
  logic [LBA_W-1:0]   chunk_lba, blk_inc;
  logic [7:0]         status;
  logic               issue;
  job_t               job;

  // Saturate the requested count
  assign cnt32   = 32'(item_i.sector_count);
  assign sat32   = (cnt32 > 32'(MAX_SECTORS)) ? 32'(MAX_SECTORS) : cnt32;
  assign sat_cnt = sat32[RW-1:0];

  assign status    = item_i.read_data[7:0];
  assign word_inc  = word_q + WC_W'(1);
  assign dummy_inc = dummy_q + 2'd1;
  assign blk_inc   = blk_q + LBA_W'(1);
  assign rem_dec   = (rem_q != '0) ? rem_q - RW'(1) : rem_q;
  assign cl_dec    = (cl_q != '0) ? cl_q - CHUNK_W'(1) : cl_q;

  // Chunk size for a new command burst
  assign rem32   = 32'(chunk_rem);
  assign lim32   = long_mode_i ? 32'(CHUNK_LIMIT48) : 32'(CHUNK_LIMIT28);
  assign chunk32 = (rem32 > lim32) ? lim32 : rem32;

  // Classify the item and step the transfer state
  always_comb begin
    phase_d   = phase_q;
    blk_d     = blk_q;
    rem_d     = rem_q;
    cl_d      = cl_q;
    word_d    = word_q;
    dummy_d   = dummy_q;
    issue     = 1'b0;
    chunk_rem = rem_q;
    chunk_lba = blk_q;
    job       = '0;
    job.act   = ACT_NONE;
    if (accept_i) begin
      if (!item_i.operation) begin
        blk_d   = item_i.start_lba;
        rem_d   = sat_cnt;
        cl_d    = '0;
        word_d  = '0;
        dummy_d = '0;
        if (sat_cnt == '0) begin
          phase_d = PH_IDLE;
          job.act = ACT_OK;
        end else begin
          issue     = 1'b1;
          chunk_rem = sat_cnt;
          chunk_lba = item_i.start_lba;
        end
      end else begin
        case (phase_q)
          PH_DUMMY: begin
            dummy_d = dummy_inc;
            if (dummy_inc == DUMMY_READS) begin
              phase_d = PH_POLL;
            end
            job.act = ACT_RD_CMD;
          end
          PH_POLL: begin
            if ((status & ST_FAULT_MASK) != 8'h00) begin
              phase_d = PH_IDLE;
              job.act = ACT_ERR;
            end else if ((status & ST_BSY) == 8'h00 && (status & ST_DRQ) != 8'h00) begin
              phase_d = PH_DATA;
              word_d  = '0;
              job.act = ACT_RD_DATA;
            end else begin
              job.act = ACT_RD_CMD;
            end
          end
          PH_DATA: begin
            job.has_data = 1'b1;
            job.data     = item_i.read_data;
            if (word_inc != WORDS_END) begin
              word_d  = word_inc;
              job.act = ACT_RD_DATA;
            end else begin
              word_d = '0;
              blk_d  = blk_inc;
              rem_d  = rem_dec;
              cl_d   = cl_dec;
              if (cl_dec != '0) begin
                dummy_d = '0;
                phase_d = PH_DUMMY;
                job.act = ACT_RD_CMD;
              end else if (rem_dec != '0) begin
                issue     = 1'b1;
                chunk_rem = rem_dec;
                chunk_lba = blk_inc;
              end else begin
                phase_d = PH_IDLE;
                job.act = ACT_OK;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (issue) begin
        cl_d          = chunk32[CHUNK_W-1:0];
        dummy_d       = '0;
        phase_d       = PH_DUMMY;
        job.act       = ACT_CHUNK;
        job.long_mode = long_mode_i;
        job.drive     = drive_i;
        job.chunk     = chunk32[CHUNK_W-1:0];
        job.lba       = chunk_lba;
      end
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i && (job.act != ACT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      blk_q   <= '0;
      rem_q   <= '0;
      cl_q    <= '0;
      word_q  <= '0;
      dummy_q <= '0;
    end else begin
      phase_q <= phase_d;
      blk_q   <= blk_d;
      rem_q   <= rem_d;
      cl_q    <= cl_d;
      word_q  <= word_d;
      dummy_q <= dummy_d;
    end
  end

endmodule

`default_nettype wire

[src/aps_back.sv]
// Back end: expands each job into result beats, one a cycle while the result queue has room.
// Depends on aps_pkg for job and result types and on aps_fifo.
`default_nettype none

module aps_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire aps_pkg::job_t  job_i,
  input  wire logic           job_valid_i,
  output logic                job_pop_o,
  input  wire logic [15:0]    io_base_i,
  output aps_pkg::res_t       res_o,
  output logic                empty_o,
  input  wire logic           pop_i
);
  import aps_pkg::*;

  logic [3:0] step_q, step_d;
  logic [3:0] n_act, total, act_idx;
  logic       is_last, gen, ofifo_full;
  beat_t      cb;
  res_t       beat;

  // Work out the current beat of the head job
  always_comb begin
    case (job_i.act)
      ACT_NONE:  n_act = 4'd0;
      ACT_CHUNK: n_act = job_i.long_mode ? BURST_BEATS48 : BURST_BEATS28;
      default:   n_act = 4'd1;
    endcase
    total   = {3'b000, job_i.has_data} + n_act;
    is_last = (step_q == total - 4'd1);
    act_idx = step_q - {3'b000, job_i.has_data};
    cb      = chunk_beat(job_i.long_mode, job_i.drive, job_i.chunk, job_i.lba, act_idx);
    beat    = '0;
    if (job_i.has_data && step_q == 4'd0) begin
      beat.kind      = KIND_DATA;
      beat.data_word = job_i.data;
    end else begin
      case (job_i.act)
        ACT_RD_CMD: begin
          beat.kind        = KIND_READ;
          beat.bus_address = io_base_i + {13'd0, OFF_CMD};
        end
        ACT_RD_DATA: begin
          beat.kind        = KIND_READ;
          beat.bus_address = io_base_i + {13'd0, OFF_DATA};
        end
        ACT_OK:  beat.kind = KIND_OK;
        ACT_ERR: beat.kind = KIND_ERR;
        ACT_CHUNK: begin
          beat.kind        = cb.is_read ? KIND_READ : KIND_WRITE;
          beat.bus_address = io_base_i + {13'd0, cb.off};
          beat.write_byte  = cb.wbyte;
        end
        default: begin
        end
      endcase
    end
    beat.last = is_last;
  end

  assign gen       = job_valid_i && !ofifo_full;
  assign job_pop_o = gen && is_last;
  assign step_d    = gen ? (is_last ? 4'd0 : step_q + 4'd1) : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // Hold finished beats until the consumer takes them
  aps_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (gen),
    .wdata_i (beat),
    .full_o  (ofifo_full),
    .pop_i   (pop_i),
    .rdata_o (res_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

[src/ata_pio_read_sequencer.sv]
// ATA PIO read sequencer, 28/48-bit LBA. A command burst leaves at one beat per cycle while the
// result queue has room (7 or 11 beats, after a data beat when a sector's last word starts it);
// other items yield one or two beats, a response while idle none. Items are taken every cycle
// while the job queue has room; the back end's one-beat-per-cycle expansion sets the sustained
// rate. Reset clears the queues, returns the transfer to idle and loads the registers with
// 28-bit mode, master drive and base 0x1F0.
`default_nettype none

module ata_pio_read_sequencer #(
  parameter int unsigned MAX_SECTORS = 8192,
  parameter int unsigned JOB_DEPTH   = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire aps_pkg::in_item_t in_item_i,
  output logic                   empty,
  input  wire logic              pop,
  output aps_pkg::res_t          res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i
);
  import aps_pkg::*;

  logic        long_mode_q, drive_q;
  logic [15:0] io_base_q;
  logic        accept, job_push, job_pop, job_full, job_empty;
  job_t        job_in, job_out;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b0;
      drive_q     <= 1'b0;
      io_base_q   <= IO_BASE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG_MODE: long_mode_q <= cfg_data_i[0];
        CFG_DRIVE:     drive_q     <= cfg_data_i[0];
        CFG_IO_BASE:   io_base_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  aps_front #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .long_mode_i (long_mode_q),
    .drive_i     (drive_q),
    .job_o       (job_in),
    .job_push_o  (job_push)
  );

  // Decouple classification from beat generation
  aps_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  aps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (!job_empty),
    .job_pop_o   (job_pop),
    .io_base_i   (io_base_q),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

[tb/aps_read_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the ATA PIO read sequencer: watches the item, result and register channels,
// predicts every result beat from its own copy of the transfer state and compares in order.
// Depends on aps_pkg for the payload structs, result kinds, offsets and status bits.

module aps_read_checker #(
  parameter int unsigned MAX_SECTORS = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  aps_pkg::in_item_t in_item_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  aps_pkg::res_t     res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o
);
  import aps_pkg::*;

  typedef enum logic [1:0] {
    XFER_IDLE,
    XFER_DUMMY,
    XFER_POLL,
    XFER_DATA
  } xfer_phase_e;

  // Register copies
  logic        long_mode;
  logic        drive_sel;
  logic [15:0] io_base;

  // Transfer state
  xfer_phase_e xfer;
  logic [47:0] cur_lba;
  logic [13:0] sectors_left;
  logic [15:0] chunk_left;
  logic [8:0]  word_cnt;
  logic [1:0]  dummies;

  res_t        step_beats[$];
  res_t        expected_beats[$];
  int unsigned fails;

  function automatic logic [15:0] reg_addr(input logic [2:0] off);
    return io_base + {13'd0, off};
  endfunction

  task automatic emit(input logic [2:0] kind, input logic [15:0] addr,
                      input logic [7:0] wbyte, input logic [15:0] word);
    res_t r;
    r.kind        = kind;
    r.bus_address = addr;
    r.write_byte  = wbyte;
    r.data_word   = word;
    r.last        = 1'b0;
    step_beats.push_back(r);
  endtask

  // Size the next chunk and queue its register writes plus the first status read
  task automatic issue_command_burst();
    logic [15:0] limit;
    logic [15:0] chunk;
    logic [7:0]  dev;
    limit = long_mode ? 16'(CHUNK_LIMIT48) : 16'(CHUNK_LIMIT28);
    chunk = ({2'b00, sectors_left} > limit) ? limit : {2'b00, sectors_left};
    chunk_left = chunk;
    dev = DEV_BASE | {3'b000, drive_sel, 4'b0000};
    if (long_mode) begin
      emit(KIND_WRITE, reg_addr(OFF_DEVSEL), dev, 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_SECCOUNT), chunk[15:8], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_SECCOUNT), chunk[7:0], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA0), cur_lba[31:24], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA0), cur_lba[7:0], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA1), cur_lba[39:32], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA1), cur_lba[15:8], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA2), cur_lba[47:40], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA2), cur_lba[23:16], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_CMD), CMD_READ48, 16'h0000);
    end else begin
      emit(KIND_WRITE, reg_addr(OFF_DEVSEL), dev | {4'h0, cur_lba[27:24]}, 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_SECCOUNT), chunk[7:0], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA0), cur_lba[7:0], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA1), cur_lba[15:8], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_LBA2), cur_lba[23:16], 16'h0000);
      emit(KIND_WRITE, reg_addr(OFF_CMD), CMD_READ28, 16'h0000);
    end
    dummies = 2'd0;
    xfer    = XFER_DUMMY;
    emit(KIND_READ, reg_addr(OFF_CMD), 8'h00, 16'h0000);
  endtask

  // Advance the transfer by one accepted item and queue the beats it causes
  task automatic predict_beats(input in_item_t it);
    logic [13:0] cnt;
    logic [7:0]  st;
    res_t        r;
    step_beats.delete();
    if (!it.operation) begin
      cnt = it.sector_count;
      if (32'(cnt) > MAX_SECTORS) cnt = 14'(MAX_SECTORS);
      cur_lba      = it.start_lba;
      sectors_left = cnt;
      chunk_left   = 16'd0;
      word_cnt     = 9'd0;
      dummies      = 2'd0;
      if (cnt == 14'd0) begin
        xfer = XFER_IDLE;
        emit(KIND_OK, 16'h0000, 8'h00, 16'h0000);
      end else begin
        issue_command_burst();
      end
    end else begin
      st = it.read_data[7:0];
      case (xfer)
        XFER_DUMMY: begin
          dummies = dummies + 2'd1;
          if (dummies == 2'd3) xfer = XFER_POLL;
          emit(KIND_READ, reg_addr(OFF_CMD), 8'h00, 16'h0000);
        end
        XFER_POLL: begin
          // Faults win over busy and data-ready
          if ((st & ST_FAULT_MASK) != 8'h00) begin
            xfer = XFER_IDLE;
            emit(KIND_ERR, 16'h0000, 8'h00, 16'h0000);
          end else if ((st & ST_BSY) == 8'h00 && (st & ST_DRQ) != 8'h00) begin
            xfer     = XFER_DATA;
            word_cnt = 9'd0;
            emit(KIND_READ, reg_addr(OFF_DATA), 8'h00, 16'h0000);
          end else begin
            emit(KIND_READ, reg_addr(OFF_CMD), 8'h00, 16'h0000);
          end
        end
        XFER_DATA: begin
          emit(KIND_DATA, 16'h0000, 8'h00, it.read_data);
          word_cnt = word_cnt + 9'd1;
          if (word_cnt < 9'(WORDS_PER_SECTOR)) begin
            emit(KIND_READ, reg_addr(OFF_DATA), 8'h00, 16'h0000);
          end else begin
            word_cnt = 9'd0;
            cur_lba  = cur_lba + 48'd1;
            if (sectors_left != 14'd0) sectors_left = sectors_left - 14'd1;
            if (chunk_left != 16'd0) chunk_left = chunk_left - 16'd1;
            if (chunk_left != 16'd0) begin
              dummies = 2'd0;
              xfer    = XFER_DUMMY;
              emit(KIND_READ, reg_addr(OFF_CMD), 8'h00, 16'h0000);
            end else if (sectors_left != 14'd0) begin
              issue_command_burst();
            end else begin
              xfer = XFER_IDLE;
              emit(KIND_OK, 16'h0000, 8'h00, 16'h0000);
            end
          end
        end
        default: ;  // responses while idle are dropped
      endcase
    end
    for (int i = 0; i < step_beats.size(); i++) begin
      r      = step_beats[i];
      r.last = (i == step_beats.size() - 1);
      expected_beats.push_back(r);
    end
  endtask

  // Compare one popped beat against the oldest expectation
  task automatic check_beat(input res_t got);
    res_t exp_b;
    if (expected_beats.size() == 0) begin
      $error("result beat with nothing expected: kind %0d address %h", got.kind,
             got.bus_address);
      fails++;
    end else begin
      exp_b = expected_beats.pop_front();
      if (got.kind !== exp_b.kind) begin
        $error("kind: expected %0d, got %0d", exp_b.kind, got.kind);
        fails++;
      end
      if (got.bus_address !== exp_b.bus_address) begin
        $error("bus_address: expected %h, got %h", exp_b.bus_address, got.bus_address);
        fails++;
      end
      if (got.write_byte !== exp_b.write_byte) begin
        $error("write_byte: expected %h, got %h", exp_b.write_byte, got.write_byte);
        fails++;
      end
      if (got.data_word !== exp_b.data_word) begin
        $error("data_word: expected %h, got %h", exp_b.data_word, got.data_word);
        fails++;
      end
      if (got.last !== exp_b.last) begin
        $error("last: expected %0d, got %0d", exp_b.last, got.last);
        fails++;
      end
    end
  endtask

  // Track register writes, items and result beats on each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode    = 1'b0;
      drive_sel    = 1'b0;
      io_base      = IO_BASE_RST;
      xfer         = XFER_IDLE;
      cur_lba      = '0;
      sectors_left = '0;
      chunk_left   = '0;
      word_cnt     = '0;
      dummies      = '0;
      expected_beats.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LONG_MODE: long_mode = cfg_data_i[0];
          CFG_DRIVE:     drive_sel = cfg_data_i[0];
          CFG_IO_BASE:   io_base   = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) predict_beats(in_item_i);
      if (pop_i && !empty_i) check_beat(res_i);
      fail_count_o  <= fails;
      outstanding_o <= unsigned'(expected_beats.size());
    end
  end

endmodule

[tb/tb_ata_pio_read_sequencer.sv]
`timescale 1ns / 100ps
// Top of the ATA PIO read sequencer testbench: clock, reset, item and register stimulus,
// random stalls on both queues and the verdict. Depends on aps_pkg, aps_read_checker and ata_pio_read_sequencer.

module tb_ata_pio_read_sequencer;
  import aps_pkg::*;

  localparam int unsigned MAX_SECTORS   = 8192;
  localparam int unsigned STALL_LIMIT   = 500;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 10;
  localparam int unsigned LONG_SECTORS  = 1;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;
  localparam logic [7:0]  ST_ERR        = 8'h01;
  localparam logic [7:0]  ST_DF         = 8'h20;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int unsigned fail_count;
  int unsigned outstanding;
  bit          idling;
  int unsigned items_sent;

  ata_pio_read_sequencer #(
    .MAX_SECTORS(MAX_SECTORS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  aps_read_checker #(
    .MAX_SECTORS(MAX_SECTORS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .in_item_i     (in_item),
    .empty_i       (empty),
    .pop_i         (pop),
    .res_i         (res),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // Favour the address edges: all ones, zero, the top of the 28-bit range
  function automatic logic [47:0] pick_lba();
    case ($urandom_range(0, 7))
      0:       return 48'hFFFF_FFFF_FFFF;
      1:       return 48'h0000_0000_0000;
      2:       return 48'h0000_0FFF_FFFF;
      default: return rand48();
    endcase
  endfunction

  // Status that keeps the poll going: no fault, and busy or not data-ready
  function automatic logic [15:0] busy_status();
    logic [15:0] d;
    d = 16'($urandom);
    d[7:0] = d[7:0] & ~ST_FAULT_MASK;
    if ((d[7:0] & ST_BSY) == 8'h00 && (d[7:0] & ST_DRQ) != 8'h00) d[7:0] = d[7:0] | ST_BSY;
    return d;
  endfunction

  function automatic logic [15:0] ready_status();
    logic [15:0] d;
    d = 16'($urandom);
    d[7:0] = (d[7:0] & ~(ST_FAULT_MASK | ST_BSY)) | ST_DRQ;
    return d;
  endfunction

  function automatic logic [15:0] fault_status();
    logic [15:0] d;
    d = 16'($urandom);
    case ($urandom_range(0, 2))
      0:       d[7:0] = d[7:0] | ST_ERR;
      1:       d[7:0] = d[7:0] | ST_DF;
      default: d[7:0] = d[7:0] | ST_FAULT_MASK;
    endcase
    return d;
  endfunction

  // Offer one beat at the falling edge and hold it until accepted
  task automatic send_item(input in_item_t it);
    if (idling && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_start(input logic [47:0] lba, input logic [13:0] cnt);
    in_item_t it;
    it.operation    = 1'b0;
    it.start_lba    = lba;
    it.sector_count = cnt;
    it.read_data    = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_resp(input logic [15:0] data);
    in_item_t it;
    it.operation    = 1'b1;
    it.start_lba    = rand48();
    it.sector_count = 14'($urandom);
    it.read_data    = data;
    send_item(it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic mode, input logic drv, input logic [15:0] base);
    write_reg(CFG_LONG_MODE, {15'($urandom), mode});
    write_reg(CFG_DRIVE, {15'($urandom), drv});
    write_reg(CFG_IO_BASE, base);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Drop push, wait for every expected beat, then let the pipeline drain
  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One read transfer, its sector cut short after a few words; sometimes faulted or disturbed
  task automatic run_transfer();
    logic [13:0] cnt;
    int unsigned n_sec;
    int unsigned n_words;
    int unsigned r;
    bit          alive;
    r = $urandom_range(0, 15);
    if (r == 0) cnt = 14'd0;
    else if (r == 1) cnt = 14'($urandom_range(MAX_SECTORS + 1, 16383));
    else if (r == 2) cnt = 14'(MAX_SECTORS);
    else cnt = 14'($urandom_range(1, 3));
    send_start(pick_lba(), cnt);
    n_sec = $urandom_range(1, 3);
    if (n_sec > cnt) n_sec = cnt;
    alive = 1'b1;
    for (int s = 0; s < n_sec && alive; s++) begin
      repeat (3) send_resp(16'($urandom));
      repeat ($urandom_range(0, 3)) send_resp(busy_status());
      r = $urandom_range(0, 15);
      if (r == 0) begin
        send_resp(fault_status());
        alive = 1'b0;
      end else begin
        if (r == 1) send_resp(16'($urandom));
        send_resp(ready_status());
        n_words = $urandom_range(1, 15);
        repeat (n_words) send_resp(16'($urandom));
        if (n_words < WORDS_PER_SECTOR) alive = 1'b0;
      end
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned target;
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_resp(16'($urandom));
      run_transfer();
    end
  endtask

  // Result side: pop in random bursts, with idle bursts while idling is on
  initial begin
    pop = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    push       = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idling     = 1'b1;
    items_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero count, idle response, saturated count, restart while busy
    send_start(48'hFFFF_FFFF_FFFF, 14'd0);
    send_resp(16'hFFFF);
    send_start(48'h0000_0000_0000, 14'h3FFF);
    send_start(48'hFFFF_FFFF_FFFF, 14'd1);
    send_resp(16'h0000);
    send_resp(16'hFFFF);
    send_resp(16'h5A5A);
    // Busy with data-ready keeps polling; error beats busy
    send_resp({8'h00, ST_BSY | ST_DRQ});
    send_resp(16'h0000);
    send_resp({8'hFF, ST_BSY | ST_DRQ | ST_ERR});
    // Device fault ends the transfer even with data-ready
    send_start(48'h0123_4567_89AB, 14'd2);
    send_resp(16'h1234);
    send_resp(16'hA5A5);
    send_resp(16'h00FF);
    send_resp({8'h00, ST_DF | ST_DRQ});
    // Data phase entered, then abandoned by a zero-count start
    send_start(48'h0000_0FFF_FFFF, 14'd1);
    send_resp(16'h0F0F);
    send_resp(16'hF0F0);
    send_resp(16'h0001);
    send_resp({8'hFF, ST_DRQ});
    send_resp(16'h0000);
    send_resp(16'hFFFF);
    send_start(48'h8000_0000_0001, 14'd0);

    // Random transfers under several register settings
    settle();
    set_regs(1'b1, 1'b1, 16'hFFFF);
    run_phase(PHASE_ITEMS);
    settle();
    set_regs(1'b0, 1'b1, 16'h0000);
    run_phase(PHASE_ITEMS);
    settle();
    set_regs(1'b1, 1'b0, 16'($urandom));
    run_phase(PHASE_ITEMS);
    settle();
    set_regs(1'b1, 1'b1, 16'hFFF9);
    run_phase(PHASE_ITEMS);

    // Full-speed 28-bit transfer of whole sectors at the top of the address range
    settle();
    idling = 1'b0;
    set_regs(1'b0, 1'b0, 16'h0170);
    send_start(48'hFFFF_FFFF_FFFF, 14'(LONG_SECTORS));
    for (int s = 0; s < LONG_SECTORS; s++) begin
      repeat (3) send_resp(16'($urandom));
      if ($urandom_range(0, 1) == 0) send_resp(busy_status());
      send_resp(ready_status());
      repeat (WORDS_PER_SECTOR) send_resp(16'($urandom));
    end
    settle();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
